[sv/sha_pkg.sv]
// ============================================================================
// SHA-256 hasher package
// Round constants, initial hash values, sequencer states and round helpers.
// ============================================================================
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  localparam int unsigned NumRounds  = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned BlockBytes = 64;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] n);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[n];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[sv/sha256_stream_hasher_top.sv]
// ============================================================================
// SHA-256 stream hasher
// Hashes a byte message that arrives as big-endian words and emits the
// eight digest words after the final item.
// ============================================================================
//  channel   direction  contents
//  s_axis    in         tdata = message_word[31:0], valid_bytes[34:32]; tlast = end_of_message
//  m_axis    out        tdata = digest_word[31:0], digest_index[34:32]; tlast = digest_last
//
// One shared round unit runs one compression round per cycle. An item is
// accepted, its valid bytes are placed in the block one at a time and a
// closing step follows. A full block adds a load step, 64 rounds and an add
// step. The final item adds padding one byte a cycle, one or two compressions
// and eight digest items. Reset returns the chaining words to the initial values.
// The input is not ready while a word is at work or a digest word waits; a
// stall on the output holds the sequencer.
module sha256_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  // end_of_message
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] digest_word, [34:32] digest_index, [39:35] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        last_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [63:0] len_q;
  logic [5:0]  pos_q;   // byte offset in the block that the pad pass writes next
  logic [5:0]  rnd_q;
  logic        fin_q;   // the running compression is the final one
  logic [2:0]  oidx_q;

  logic [5:0]  off;
  assign off = len_q[8:3];

  // Schedule and round datapath for the current round.
  logic [31:0] wt, s0, s1, wnew, t1, t2;
  logic [3:0]  ri;
  assign ri = rnd_q[3:0];
  always_comb begin
    s1   = rotr(w_q[ri - 4'd2], 17) ^ rotr(w_q[ri - 4'd2], 19) ^ (w_q[ri - 4'd2] >> 10);
    s0   = rotr(w_q[ri - 4'd15], 7) ^ rotr(w_q[ri - 4'd15], 18) ^ (w_q[ri - 4'd15] >> 3);
    wnew = s1 + w_q[ri - 4'd7] + s0 + w_q[ri];
    wt   = (rnd_q >= 6'd16) ? wnew : w_q[ri];
    t1   = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
         + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wt;
    t2   = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_BYTE;
      ST_BYTE: begin
        if (cnt_q != 3'd0) begin
          if (off == 6'd63) state_d = ST_LOAD;
        end else if (last_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_PAD: begin
        if (pos_q == 6'd63) state_d = ST_LOAD;
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'(NumRounds - 1)) state_d = ST_ADD;
      ST_ADD: begin
        if (fin_q) state_d = ST_EMIT;
        else if (cnt_q != 3'd0) state_d = ST_BYTE;
        else if (last_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_EMIT: if (m_axis_tready && oidx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_EMIT);
    m_axis_tdata  = {5'd0, oidx_q, h_q[oidx_q]};
    m_axis_tlast  = (oidx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      oidx_q  <= '0;
      pos_q   <= '0;
      for (int n = 0; n < 8; n++) begin
        h_q[n] <= init_hash(3'(n));
        v_q[n] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            word_q <= s_axis_tdata[31:0];
            cnt_q  <= (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
            last_q <= s_axis_tlast;
            fin_q  <= 1'b0;
          end
        end
        ST_BYTE: begin
          // Place one message byte at the current offset.
          if (cnt_q != 3'd0) begin
            if (off[1:0] == 2'd0) w_q[off[5:2]] <= {word_q[31:24], 24'd0};
            else w_q[off[5:2]][(3 - off[1:0]) * 8 +: 8] <= word_q[31:24];
            word_q <= {word_q[23:0], 8'd0};
            cnt_q  <= cnt_q - 3'd1;
            len_q  <= len_q + 64'd8;
          end else begin
            pos_q <= off;
          end
        end
        ST_PAD: begin
          // 0x80 at the message end, zeros, then the length in the last eight bytes.
          if (pos_q == off && !fin_q && pos_q[1:0] == 2'd0)
            w_q[pos_q[5:2]] <= 32'h8000_0000;
          else if (pos_q == off && !fin_q)
            w_q[pos_q[5:2]][(3 - pos_q[1:0]) * 8 +: 8] <= 8'h80;
          else if (pos_q[1:0] == 2'd0)
            w_q[pos_q[5:2]] <= '0;
          if (pos_q == 6'd63) begin
            if (off < 6'(LenOffset) || fin_q) begin
              w_q[14] <= len_q[63:32];
              w_q[15] <= len_q[31:0];
              last_q  <= 1'b1;
              fin_q   <= 1'b1;
            end else begin
              fin_q <= 1'b0;
            end
          end
          pos_q <= pos_q + 6'd1;
        end
        ST_LOAD: begin
          for (int n = 0; n < 8; n++) v_q[n] <= h_q[n];
          rnd_q <= '0;
        end
        ST_ROUND: begin
          if (rnd_q >= 6'd16) w_q[ri] <= wnew;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
        end
        ST_ADD: begin
          for (int n = 0; n < 8; n++) h_q[n] <= h_q[n] + v_q[n];
          // After an overflow pad block the next pad pass starts at zero.
          if (!fin_q && cnt_q == 3'd0 && last_q && state_d == ST_PAD) begin
            pos_q <= '0;
            fin_q <= pos_q == 6'd0 && off >= 6'(LenOffset);
          end
          oidx_q <= '0;
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              len_q  <= '0;
              fin_q  <= 1'b0;
              last_q <= 1'b0;
              for (int n = 0; n < 8; n++) begin
                h_q[n] <= init_hash(3'(n));
                v_q[n] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/sha256_stream_hasher_top_tb.sv]
// ============================================================================
// SHA-256 stream hasher testbench
// Drives byte messages as big-endian words with random burst gaps, stalls the
// digest side on its own pattern and compares every digest item against a
// self-contained SHA-256 predictor.
// ============================================================================
module sha256_stream_hasher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        eom;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_stream_hasher_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  msg_item_t    pending_words[$];
  digest_item_t expected_digest[$];
  int unsigned  error_count;
  int unsigned  idle_cycles;
  int unsigned  gap_left;
  int unsigned  burst_left;
  int unsigned  stall_phase;
  int unsigned  words_sent;
  int unsigned  digests_seen;
  int unsigned  messages_sent;
  bit           stimulus_done;

  // Predictor state: chaining words, block buffer and running bit count.
  logic [31:0] hash_state[8];
  logic [31:0] block_buf[16];
  logic [63:0] msg_bits;

  localparam logic [31:0] RoundConst[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] StartHash[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_hash();
    for (int n = 0; n < 8; n++) hash_state[n] = StartHash[n];
    for (int n = 0; n < 16; n++) block_buf[n] = '0;
    msg_bits = '0;
  endtask

  // One 64-round compression of the block buffer into the chaining words.
  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = block_buf[t];
    for (int t = 16; t < 64; t++) begin
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int n = 0; n < 8; n++) v[n] = hash_state[n];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int n = 0; n < 8; n++) hash_state[n] += v[n];
  endtask

  task automatic put_byte(int unsigned pos, logic [7:0] b);
    int unsigned wi;
    int unsigned sh;
    wi = (pos >> 2) & 15;
    sh = (3 - (pos & 3)) * 8;
    if ((pos & 3) == 0) block_buf[wi] = 32'(b) << sh;
    else block_buf[wi] |= 32'(b) << sh;
  endtask

  // Advances the predictor by one accepted item and queues any digest items.
  task automatic hash_word(msg_item_t it);
    int unsigned cnt;
    int unsigned off;
    digest_item_t d;
    cnt = (it.nbytes > 4) ? 4 : it.nbytes;
    for (int n = 0; n < cnt; n++) begin
      put_byte(msg_bits[8:3], it.word[31-8*n -: 8]);
      msg_bits += 64'd8;
      if (msg_bits[8:3] == 0) compress_block();
    end
    if (it.eom) begin
      off = msg_bits[8:3];
      put_byte(off, 8'h80);
      off++;
      if (off > 56) begin
        while (off < 64) put_byte(off++, 8'h00);
        compress_block();
        off = 0;
      end
      while (off < 56) put_byte(off++, 8'h00);
      block_buf[14] = msg_bits[63:32];
      block_buf[15] = msg_bits[31:0];
      compress_block();
      for (int n = 0; n < 8; n++) begin
        d.word = hash_state[n];
        d.index = 3'(n);
        d.last = (n == 7);
        expected_digest.push_back(d);
      end
      clear_hash();
    end
  endtask

  task automatic add_word(logic [31:0] w, int unsigned nb, bit eom);
    msg_item_t it;
    it.word = w;
    it.nbytes = 3'(nb);
    it.eom = eom;
    pending_words.push_back(it);
  endtask

  // Queues a message of nbytes random bytes, mostly full words.
  task automatic add_message(int unsigned nbytes, bit odd_words);
    int unsigned left;
    int unsigned nb;
    left = nbytes;
    while (left > 4) begin
      nb = (odd_words && $urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 4;
      if (nb > 4) nb = (nb == 7) ? 7 : nb;
      add_word($urandom, nb, 1'b0);
      left -= (nb > 4) ? 4 : nb;
    end
    add_word($urandom, left, 1'b1);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stimulus: directed messages, then random ones.
  initial begin
    rst_ni = 1'b0;
    stimulus_done = 1'b0;
    clear_hash();
    // Empty message.
    add_word(32'hffffffff, 0, 1'b1);
    // "abc" with junk below the valid bytes.
    add_word(32'h616263ff, 3, 1'b1);
    // Short words mid-message, a zero-count word and counts above four.
    add_word(32'h00000000, 1, 1'b0);
    add_word(32'hffffffff, 0, 1'b0);
    add_word(32'hffffffff, 2, 1'b0);
    add_word(32'haaaaaaaa, 5, 1'b0);
    add_word(32'h55555555, 6, 1'b0);
    add_word(32'h12345678, 7, 1'b1);
    // A 55-byte message, the longest that fits a single padding block.
    for (int n = 0; n < 13; n++) add_word($urandom, 4, 1'b0);
    add_word(32'hdeadbeef, 3, 1'b1);
    while (pending_words.size() < 212) begin
      case ($urandom_range(0, 3))
        0: add_message($urandom_range(0, 8), 1'b1);
        1: add_message($urandom_range(52, 68), 1'b1);
        2: add_message($urandom_range(0, 40), 1'b1);
        default: add_message($urandom_range(100, 140), 1'b0);
      endcase
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    stimulus_done = 1'b1;
  end

  // Driver: bursts of items separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      gap_left <= 0;
      burst_left <= 4;
      words_sent <= 0;
      messages_sent <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hash_word(pending_words.pop_front());
        words_sent <= words_sent + 1;
        if (s_axis_tlast) messages_sent <= messages_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, pending_words[0].nbytes, pending_words[0].word};
          s_axis_tlast <= pending_words[0].eom;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: alternating free-running and random phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[7:6] == 2'b00) m_axis_tready <= 1'b1;
      else if (stall_phase[7:6] == 2'b01) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= ($urandom_range(0, 2) == 0);
    end
  end

  // Monitor: compares each digest item with the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin
    digest_item_t exp_d;
    if (!rst_ni) begin
      error_count <= 0;
      digests_seen <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      digests_seen <= digests_seen + 1;
      if (expected_digest.size() == 0) begin
        $display("%0t: unexpected digest item word=%h index=%0d last=%b", $time,
                 m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
        error_count <= error_count + 1;
      end else begin
        exp_d = expected_digest.pop_front();
        if (m_axis_tdata[31:0] !== exp_d.word || m_axis_tdata[34:32] !== exp_d.index
            || m_axis_tlast !== exp_d.last) begin
          $display("%0t: digest mismatch expected word=%h index=%0d last=%b, %s",
                   $time, exp_d.word, exp_d.index, exp_d.last,
                   $sformatf("got word=%h index=%0d last=%b",
                             m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast));
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    wait (stimulus_done);
    while (pending_words.size() > 0 || s_axis_tvalid || expected_digest.size() > 0) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout with %0d digest items outstanding", $time,
                 expected_digest.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
    repeat (DrainCycles) @(posedge clk_i);
    $display("Hashed %0d messages from %0d items; checked %0d digest items.",
             messages_sent, words_sent, digests_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
